// ===== hw/rtl/pool_hash_random_generator_unit_macros.svh =====
// Assertion macros for the checker file.
`ifndef POOL_HASH_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define POOL_HASH_RANDOM_GENERATOR_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PHRG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pool hash generator check failed");

// Check a property on every clock edge, reset included.
`define PHRG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("pool hash generator check failed");

`endif

// ===== hw/rtl/phrg_pkg.sv =====
// Constants, types and helpers for the pool hash random generator.
`timescale 1ns / 1ps
package phrg_pkg;

   localparam int unsigned POOL_WORDS_DEFAULT = 64;
   localparam int unsigned WORD_W             = 32;
   localparam int unsigned INDEX_W            = 6;
   localparam int unsigned INDEX_COUNT        = 2 ** INDEX_W;

   localparam logic [WORD_W-1:0] HASH_MUL = 32'h0100_0193;
   localparam logic [WORD_W-1:0] LCG_MULT = 32'h41C6_4E6D;
   localparam logic [WORD_W-1:0] LCG_INC  = 32'd12345;

   typedef enum logic [0:0] {
      OP_DRAW   = 1'b0,
      OP_RESEED = 1'b1
   } opcode_type;

   function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// ===== hw/rtl/pool_hash_random_generator_unit.sv =====
// Pool hash random generator: seed, word pool in one memory, and draw sequencer.
`timescale 1ns / 1ps
// A reseed word returns nothing: it loads the seed, zeroes the index and marks every pool entry
// empty through per-entry flags, so no clearing pass is needed. A draw walks the pool in ST_HASH,
// lets the last read return in ST_DRAIN and offers its result from ST_FINISH: the pool memory
// has one read port, and the hash walks it one word per cycle, folding each word into the running
// hash with a constant multiply. The next word is taken once the result sits in the output
// register; a new draw result waits there until the consumer frees it.
module pool_hash_random_generator_unit
   import phrg_pkg::*;
#(
   parameter int unsigned POOL_WORDS = POOL_WORDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [WORD_W-1:0]   req_new_seed,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_random_word
);

   localparam int unsigned ADDR_W = $clog2(POOL_WORDS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_WORDS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [WORD_W-1:0]       seed_ff, seed_in;
   logic [WORD_W-1:0]       hash_ff, hash_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       rd_tag_ff, rd_tag_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [WORD_W-1:0]       rd_data_ff;
   logic [WORD_W-1:0]       slot_word_ff, slot_word_in;
   logic [INDEX_W-1:0]      index_ff, index_in;
   logic [POOL_WORDS-1:0]   valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]       rsp_word_ff, rsp_word_in;
   logic                    mem_we;

   logic [WORD_W-1:0]       pool_mem [POOL_WORDS];
   logic [ADDR_W-1:0]       slot_lut [INDEX_COUNT];

   logic [ADDR_W-1:0]       slot;
   logic [WORD_W-1:0]       hash_mul;
   logic [WORD_W-1:0]       seed_step;
   logic [WORD_W-1:0]       rd_word;
   logic [WORD_W-1:0]       sum;

   for (genvar i = 0; i < INDEX_COUNT; i++) begin : g_slot
      assign slot_lut[i] = ADDR_W'(i % POOL_WORDS);
   end

   assign slot      = slot_lut[index_ff];
   assign hash_mul  = 32'(hash_ff * HASH_MUL);
   assign seed_step = 32'(seed_ff * LCG_MULT + LCG_INC);
   assign rd_word   = rd_ok_ff ? rd_data_ff : '0;
   assign sum       = hash_ff ^ seed_ff;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      hash_in      = hash_ff;
      addr_in      = addr_ff;
      rd_tag_in    = addr_ff;
      rd_pend_in   = 1'b0;
      rd_ok_in     = valid_ff[addr_ff];
      slot_word_in = slot_word_ff;
      index_in     = index_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      mem_we       = 1'b0;

      // fold the returning pool word into the hash
      if (rd_pend_ff) begin
         hash_in = hash_mul ^ swap_bytes(rd_word);
         if (rd_tag_ff == slot) begin
            slot_word_in = rd_word;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_RESEED) begin
                  seed_in  = req_new_seed;
                  valid_in = '0;
                  index_in = '0;
               end else begin
                  hash_in  = seed_ff;
                  seed_in  = seed_step;
                  addr_in  = '0;
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            rd_pend_in = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               mem_we         = 1'b1;
               valid_in[slot] = 1'b1;
               index_in       = sum[INDEX_W-1:0];
               rsp_valid_in   = 1'b1;
               rsp_word_in    = sum;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         index_ff     <= '0;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         index_ff     <= index_in;
         valid_ff     <= valid_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff      <= hash_in;
      addr_ff      <= addr_in;
      rd_tag_ff    <= rd_tag_in;
      rd_ok_ff     <= rd_ok_in;
      slot_word_ff <= slot_word_in;
      rsp_word_ff  <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem[slot] <= slot_word_ff ^ sum;
      end
      rd_data_ff <= pool_mem[addr_ff];
   end

endmodule

// ===== hw/rtl/phrg_checker.sv =====
// Port-level checks for the pool hash random generator, bound to the top level.
`timescale 1ns / 1ps
`include "pool_hash_random_generator_unit_macros.svh"
module phrg_checker
   import phrg_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_opcode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [WORD_W-1:0]   rsp_random_word
);

   `PHRG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `PHRG_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_random_word))
   `PHRG_ASSERT(a_draw_busy, clock, reset, req_valid && req_ready && req_opcode == OP_DRAW |=> !req_ready)
   `PHRG_ASSERT(a_reseed_silent, clock, reset, req_valid && req_ready && req_opcode == OP_RESEED && !rsp_valid |=> !rsp_valid)
   `PHRG_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind pool_hash_random_generator_unit phrg_checker u_phrg_checker (.*);
